// ===== sv/sle_pkg.sv =====
// sle_pkg: item types, command codes and sequencer states for the list engine
// used by sle_cmp, sequential_list_engine_core and sle_checker
// no dependencies
`default_nettype none

package sle_pkg;

    // fixed field widths of the item formats
    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;

    // command codes carried in the cmd field
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT       = 3'd0,
        CMD_DELETE       = 3'd1,
        CMD_LOCATE       = 3'd2,
        CMD_DELETE_MIN   = 3'd3,
        CMD_REMOVE_VALUE = 3'd4,
        CMD_REMOVE_RANGE = 3'd5
    } sle_cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUT,
        ST_DONE
    } sle_state_t;

    // command item
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] range_high;
    } sle_in_t;

    // result item
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] element_out;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         length_now;
    } sle_out_t;

    // flags from the shared compare unit
    typedef struct packed {
        logic eq;
        logic lt_min;
        logic below_lo;
        logic above_hi;
    } sle_cmp_t;

endpackage

`default_nettype wire

// ===== sv/sle_cmp.sv =====
// sle_cmp: shared signed compare unit of the list engine
// one element against the key, the range bounds and the running minimum
// depends on sle_pkg
`default_nettype none

module sle_cmp (
    input  wire logic [sle_pkg::DATA_W-1:0] elem,
    input  wire logic [sle_pkg::DATA_W-1:0] key,
    input  wire logic [sle_pkg::DATA_W-1:0] bound_hi,
    input  wire logic [sle_pkg::DATA_W-1:0] cur_min,
    output sle_pkg::sle_cmp_t               flags
);
    import sle_pkg::*;

    // signed comparisons of the element
    always_comb
    begin
        flags.eq       = (elem == key);
        flags.lt_min   = ($signed(elem) < $signed(cur_min));
        flags.below_lo = ($signed(elem) < $signed(key));
        flags.above_hi = ($signed(elem) > $signed(bound_hi));
    end

endmodule

`default_nettype wire

// ===== sv/sequential_list_engine_core.sv =====
// sequential_list_engine_core: fixed-capacity ordered list with insert, delete,
// locate, delete-minimum and compaction commands over an element store with one write port and one read port
// depends on sle_pkg and sle_cmp
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------
//  cmd     | in        | cmd_valid / cmd_ready | cmd_item (sle_in_t)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_item (sle_out_t)
//
// one item at a time, the store walked one element per cycle through its single
// registered read port, at most the length in elements; insert and delete-minimum
// write one more element after the walk, also an insert at the tail, which reads
// nothing; rejected and unknown commands skip the walk
// the store needs no clearing after reset; a waiting result stalls only the next completion
`default_nettype none

module sequential_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire sle_pkg::sle_in_t cmd_item,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output sle_pkg::sle_out_t     rsp_item
);
    import sle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    // element store
    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] mem_q;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    // sequencer and datapath registers
    sle_state_t        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [AW-1:0]     put_addr_reg, put_addr_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [LW-1:0]     cnt_reg, cnt_next;
    logic              down_reg, down_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [LW-1:0]     k_reg, k_next;
    logic [LW-1:0]     found_reg, found_next;
    logic [DATA_W-1:0] min_reg, min_next;
    logic [AW-1:0]     at_reg, at_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic [DATA_W-1:0] elem_reg, elem_next;
    logic              ok_reg, ok_next;
    logic [LW-1:0]     len_reg, len_next;
    sle_out_t          out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // start decode
    logic              accept;
    logic [CW-1:0]     pos_x;
    logic [CW-1:0]     len_x;
    logic              ins_ok;
    logic              del_ok;
    logic              go_scan;
    logic              start_ok;
    logic              load_out;
    logic              scan_end;

    // compare unit operands
    logic [DATA_W-1:0] cmp_elem;
    logic [DATA_W-1:0] cmp_key;
    logic [DATA_W-1:0] cmp_hi;
    logic [DATA_W-1:0] cmp_min;
    sle_cmp_t          cmp_flags;

    assign accept    = cmd_valid && cmd_ready;
    assign pos_x     = CW'(cmd_item.position);
    assign len_x     = CW'(len_reg);
    assign ins_ok    = (pos_x >= CW'(1)) && (pos_x <= len_x + CW'(1))
                       && (len_x < CW'(CAPACITY));
    assign del_ok    = (pos_x >= CW'(1)) && (pos_x <= len_x);
    assign scan_end  = (cnt_reg == '0) && !rd_vld_reg;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || rsp_ready);
    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    // compare unit: range check at start, element checks while scanning
    assign cmp_elem = (state_reg == ST_IDLE) ? cmd_item.value : mem_q;
    assign cmp_key  = value_reg;
    assign cmp_hi   = hi_reg;
    assign cmp_min  = (state_reg == ST_IDLE) ? cmd_item.range_high : min_reg;

    sle_cmp u_cmp (
        .elem     (cmp_elem),
        .key      (cmp_key),
        .bound_hi (cmp_hi),
        .cur_min  (cmp_min),
        .flags    (cmp_flags)
    );

    // command check at acceptance
    always_comb
    begin
        go_scan  = 1'b0;
        start_ok = 1'b0;
        case (cmd_item.cmd)
            CMD_INSERT:
            begin
                go_scan  = ins_ok;
                start_ok = ins_ok;
            end
            CMD_DELETE:
            begin
                go_scan  = del_ok;
                start_ok = del_ok;
            end
            CMD_LOCATE:
            begin
                go_scan  = 1'b1;
            end
            CMD_DELETE_MIN:
            begin
                go_scan  = (len_reg != '0);
                start_ok = (len_reg != '0);
            end
            CMD_REMOVE_VALUE:
            begin
                go_scan  = 1'b1;
                start_ok = 1'b1;
            end
            CMD_REMOVE_RANGE:
            begin
                go_scan  = cmp_flags.lt_min && (len_reg != '0);
                start_ok = cmp_flags.lt_min && (len_reg != '0);
            end
            default:
            begin
                go_scan  = 1'b0;
                start_ok = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = go_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (cmd_reg == CMD_INSERT || cmd_reg == CMD_DELETE_MIN)
                        state_next = ST_PUT;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_PUT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        hi_next        = hi_reg;
        put_addr_next  = put_addr_reg;
        rp_next        = rp_reg;
        cnt_next       = cnt_reg;
        down_next      = down_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        min_next       = min_reg;
        at_next        = at_reg;
        last_next      = last_reg;
        elem_next      = elem_reg;
        ok_next        = ok_reg;
        len_next       = len_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = mem_q;
        mem_re         = 1'b0;
        mem_raddr      = rp_reg;

        if (rsp_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // latch the item and set up the walk
                if (accept)
                begin
                    cmd_next      = cmd_item.cmd;
                    value_next    = cmd_item.value;
                    hi_next       = cmd_item.range_high;
                    put_addr_next = AW'(pos_x - CW'(1));
                    k_next        = '0;
                    found_next    = '0;
                    elem_next     = '0;
                    ok_next       = start_ok;
                    down_next     = (cmd_item.cmd == CMD_INSERT);
                    rp_next       = '0;
                    cnt_next      = len_reg;
                    if (cmd_item.cmd == CMD_INSERT)
                    begin
                        rp_next  = AW'(len_x - CW'(1));
                        cnt_next = LW'(len_x - pos_x + CW'(1));
                    end
                    else if (cmd_item.cmd == CMD_DELETE)
                    begin
                        rp_next  = AW'(pos_x - CW'(1));
                        cnt_next = LW'(len_x - pos_x + CW'(1));
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle
                if (cnt_reg != '0)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rp_reg;
                    rd_vld_next = 1'b1;
                    rd_idx_next = rp_reg;
                    rp_next     = down_reg ? rp_reg - AW'(1) : rp_reg + AW'(1);
                    cnt_next    = cnt_reg - LW'(1);
                end
                // handle the element read in the previous cycle
                if (rd_vld_reg)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = rd_idx_reg + AW'(1);
                        end
                        CMD_DELETE:
                        begin
                            if (rd_idx_reg == put_addr_reg)
                                elem_next = mem_q;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = rd_idx_reg - AW'(1);
                            end
                        end
                        CMD_LOCATE:
                        begin
                            if (cmp_flags.eq && found_reg == '0)
                            begin
                                found_next = LW'(rd_idx_reg) + LW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        CMD_DELETE_MIN:
                        begin
                            if (rd_idx_reg == '0 || cmp_flags.lt_min)
                            begin
                                min_next = mem_q;
                                at_next  = rd_idx_reg;
                            end
                            if (LW'(rd_idx_reg) == len_reg - LW'(1))
                                last_next = mem_q;
                        end
                        CMD_REMOVE_VALUE:
                        begin
                            if (!cmp_flags.eq)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = k_reg[AW-1:0];
                                k_next    = k_reg + LW'(1);
                            end
                        end
                        CMD_REMOVE_RANGE:
                        begin
                            if (cmp_flags.below_lo || cmp_flags.above_hi)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = k_reg[AW-1:0];
                                k_next    = k_reg + LW'(1);
                            end
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                // place the new element, or fill the minimum's slot with the last
                mem_we = 1'b1;
                if (cmd_reg == CMD_INSERT)
                begin
                    mem_waddr = put_addr_reg;
                    mem_wdata = value_reg;
                end
                else
                begin
                    mem_waddr = at_reg;
                    mem_wdata = last_reg;
                    elem_next = min_reg;
                end
            end
            ST_DONE:
            begin
                // new length and result item
                if (load_out)
                begin
                    if (ok_reg)
                    begin
                        case (cmd_reg)
                            CMD_INSERT:       len_next = len_reg + LW'(1);
                            CMD_DELETE:       len_next = len_reg - LW'(1);
                            CMD_DELETE_MIN:   len_next = len_reg - LW'(1);
                            CMD_REMOVE_VALUE: len_next = k_reg;
                            CMD_REMOVE_RANGE: len_next = k_reg;
                            default:          len_next = len_reg;
                        endcase
                    end
                    out_next.ok             = ok_reg;
                    out_next.element_out    = elem_reg;
                    out_next.found_position = POS_W'(found_reg);
                    out_next.length_now     = POS_W'(len_next);
                    out_valid_next          = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // element store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        value_reg    <= value_next;
        hi_reg       <= hi_next;
        put_addr_reg <= put_addr_next;
        rp_reg       <= rp_next;
        down_reg     <= down_next;
        rd_idx_reg   <= rd_idx_next;
        k_reg        <= k_next;
        found_reg    <= found_next;
        min_reg      <= min_next;
        at_reg       <= at_next;
        last_reg     <= last_next;
        elem_reg     <= elem_next;
        ok_reg       <= ok_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire

// ===== sv/sle_checker.sv =====
// sle_checker: port-level checks on the list engine, bound to the top level
// depends on sle_pkg and sequential_list_engine_core
`default_nettype none

module sle_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire sle_pkg::sle_in_t  cmd_item,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire sle_pkg::sle_out_t rsp_item
);
    import sle_pkg::*;

    // a waiting result holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("result item changed while stalled");

    // the engine is busy right after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while busy");

    // a failed command reports no element and no position
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.ok |->
            rsp_item.element_out == '0 && rsp_item.found_position == '0)
        else $error("failed command carries data");

    // a found position is never beyond the reported length
    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.found_position != '0 |->
            rsp_item.ok && (CAPACITY > 31 ||
                rsp_item.found_position <= rsp_item.length_now))
        else $error("found position out of range");

    // length never passes capacity
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> CAPACITY > 31 || rsp_item.length_now <= CAPACITY)
        else $error("length above capacity");

endmodule

bind sequential_list_engine_core sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
);

`default_nettype wire

// ===== dv/tb_sequential_list_engine_core.sv =====
// tb_sequential_list_engine_core: self-checking bench for the list engine with a scoreboard
// class that tracks its own copy of the list and predicts every result item
// depends on sle_pkg and sequential_list_engine_core
`default_nettype none

module tb_sequential_list_engine_core;

    import sle_pkg::*;

    localparam int LIST_CAP    = 16;
    localparam int RANDOM_CMDS = 1500;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 40;

    // command codes the block has to ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // list shadow and result checking
    class list_scoreboard;
        logic signed [DATA_W-1:0] slots [LIST_CAP];
        int       count;
        sle_out_t awaited_q [$];
        int       errors;
        int       checked;
        int       accepted;
        int       full_rejects;
        int       peak;

        function new();
            count        = 0;
            errors       = 0;
            checked      = 0;
            accepted     = 0;
            full_rejects = 0;
            peak         = 0;
        endfunction

        // apply one accepted command item to the shadow list and queue its result
        function void note_cmd(sle_in_t it);
            sle_out_t                 want;
            int                       pos;
            int                       at;
            int                       kept;
            logic signed [DATA_W-1:0] lo;
            logic signed [DATA_W-1:0] hi;
            pos  = int'(it.position);
            lo   = it.value;
            hi   = it.range_high;
            want = '0;
            accepted++;
            case (it.cmd)
                CMD_INSERT:
                begin
                    if (pos >= 1 && pos <= count + 1 && count < LIST_CAP)
                    begin
                        for (int j = count; j >= pos; j--)
                            slots[j] = slots[j-1];
                        slots[pos-1] = lo;
                        count++;
                        want.ok = 1'b1;
                    end
                    else if (count == LIST_CAP)
                        full_rejects++;
                end
                CMD_DELETE:
                begin
                    if (pos >= 1 && pos <= count)
                    begin
                        want.element_out = slots[pos-1];
                        for (int j = pos; j < count; j++)
                            slots[j-1] = slots[j];
                        count--;
                        want.ok = 1'b1;
                    end
                end
                CMD_LOCATE:
                begin
                    for (int j = 0; j < count; j++)
                    begin
                        if (slots[j] == lo && !want.ok)
                        begin
                            want.found_position = POS_W'(j + 1);
                            want.ok             = 1'b1;
                        end
                    end
                end
                CMD_DELETE_MIN:
                begin
                    if (count > 0)
                    begin
                        // first occurrence wins on ties, last element fills the hole
                        at = 0;
                        for (int j = 1; j < count; j++)
                            if (slots[j] < slots[at])
                                at = j;
                        want.element_out = slots[at];
                        slots[at]        = slots[count-1];
                        count--;
                        want.ok = 1'b1;
                    end
                end
                CMD_REMOVE_VALUE:
                begin
                    kept = 0;
                    for (int j = 0; j < count; j++)
                    begin
                        if (slots[j] != lo)
                        begin
                            slots[kept] = slots[j];
                            kept++;
                        end
                    end
                    count   = kept;
                    want.ok = 1'b1;
                end
                CMD_REMOVE_RANGE:
                begin
                    if (lo < hi && count > 0)
                    begin
                        kept = 0;
                        for (int j = 0; j < count; j++)
                        begin
                            if (slots[j] < lo || slots[j] > hi)
                            begin
                                slots[kept] = slots[j];
                                kept++;
                            end
                        end
                        count   = kept;
                        want.ok = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (count > peak)
                peak = count;
            want.length_now = POS_W'(count);
            awaited_q.push_back(want);
        endfunction

        // compare one result item with the oldest prediction
        function void check_rsp(sle_out_t got);
            sle_out_t want;
            if (awaited_q.size() == 0)
            begin
                errors++;
                $display("%0t: result item with nothing outstanding: ok=%0b elem=%0d pos=%0d len=%0d",
                         $time, got.ok, got.element_out, got.found_position, got.length_now);
                return;
            end
            want = awaited_q.pop_front();
            checked++;
            if (got.ok !== want.ok)
            begin
                errors++;
                $display("%0t: ok mismatch: expected %0b, got %0b", $time, want.ok, got.ok);
            end
            if (got.element_out !== want.element_out)
            begin
                errors++;
                $display("%0t: element_out mismatch: expected %0d, got %0d",
                         $time, want.element_out, got.element_out);
            end
            if (got.found_position !== want.found_position)
            begin
                errors++;
                $display("%0t: found_position mismatch: expected %0d, got %0d",
                         $time, want.found_position, got.found_position);
            end
            if (got.length_now !== want.length_now)
            begin
                errors++;
                $display("%0t: length_now mismatch: expected %0d, got %0d",
                         $time, want.length_now, got.length_now);
            end
        endfunction

        function int outstanding();
            return awaited_q.size();
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    sle_in_t  cmd_item  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    sle_out_t rsp_item;

    list_scoreboard sb = new();

    int cycle_count = 0;
    int sink_mode   = 0;
    int mode_left   = 0;
    int stall_left  = 0;

    sequential_list_engine_core #(
        .CAPACITY (LIST_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_sequential_list_engine_core failed");
            $finish;
        end
    end

    // result side back-pressure: always ready, coin toss, or rare long stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            sink_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(64, 256);
        end
        else
            mode_left <= mode_left - 1;

        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if (sink_mode == 0)
            rsp_ready <= 1'b1;
        else if (sink_mode == 1)
            rsp_ready <= 1'($urandom_range(0, 1));
        else if ($urandom_range(0, 39) == 0)
        begin
            stall_left <= $urandom_range(10, 40);
            rsp_ready  <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_rsp(rsp_item);
    end

    // idle cycles before the next item: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // present one item and hold it until accepted
    task automatic drive_cmd(sle_in_t it, int gap);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do
            @(posedge clk);
        while (!cmd_ready);
        sb.note_cmd(it);
    endtask

    task automatic issue(logic [CMD_W-1:0] c, int p, logic signed [DATA_W-1:0] v,
                         logic signed [DATA_W-1:0] h);
        sle_in_t it;
        it.cmd        = c;
        it.position   = POS_W'(p);
        it.value      = v;
        it.range_high = h;
        drive_cmd(it, pick_gap());
    endtask

    // values: often one already in the list, often small, sometimes extreme
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (sb.count > 0 && r < 40)
            return sb.slots[$urandom_range(0, sb.count - 1)];
        else if (r < 70)
            return DATA_W'($urandom_range(0, 8)) - 32'sd4;
        else if (r < 75)
            return VAL_MIN;
        else if (r < 80)
            return VAL_MAX;
        else
            return $urandom;
    endfunction

    // one random command, shaped by the current list length
    function automatic sle_in_t random_cmd();
        sle_in_t it;
        int      n;
        int      r;
        int      insert_weight;
        n  = sb.count;
        it.value      = pick_value();
        it.range_high = $urandom;
        it.position   = POS_W'($urandom_range(0, 31));
        insert_weight = (n < 6) ? 50 : (n == LIST_CAP) ? 15 : 35;
        if ($urandom_range(0, 99) < insert_weight)
        begin
            it.cmd = CMD_INSERT;
            if ($urandom_range(0, 4) != 0)
                it.position = POS_W'($urandom_range(1, n + 1));
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
                it.cmd = CMD_DELETE;
            else if (r < 44)
                it.cmd = CMD_LOCATE;
            else if (r < 60)
                it.cmd = CMD_DELETE_MIN;
            else if (r < 74)
                it.cmd = CMD_REMOVE_VALUE;
            else if (r < 96)
                it.cmd = CMD_REMOVE_RANGE;
            else if (r < 98)
                it.cmd = CMD_SPARE_A;
            else
                it.cmd = CMD_SPARE_B;
            if (it.cmd == CMD_DELETE && n > 0 && $urandom_range(0, 4) != 0)
                it.position = POS_W'($urandom_range(1, n));
            // narrow ranges around present values, sometimes reversed or empty
            if (it.cmd == CMD_REMOVE_RANGE)
            begin
                if ($urandom_range(0, 9) < 7)
                    it.range_high = it.value + DATA_W'($urandom_range(0, 8));
                else
                    it.range_high = pick_value();
            end
        end
        return it;
    endfunction

    // stimulus and end of run
    initial
    begin
        logic signed [DATA_W-1:0] v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // failures on an empty list
        issue(CMD_DELETE, 1, 32'sd7, 32'sd0);
        issue(CMD_DELETE_MIN, 0, 32'sd0, 32'sd0);
        issue(CMD_REMOVE_RANGE, 0, -32'sd5, 32'sd5);
        issue(CMD_INSERT, 0, 32'sd3, 32'sd0);
        issue(CMD_INSERT, 2, 32'sd3, 32'sd0);

        // fill to capacity at front, tail and middle, with extremes and a tied minimum
        for (int i = 0; i < LIST_CAP; i++)
        begin
            v = (i == 0 || i == 4) ? VAL_MIN : (i == 1) ? VAL_MAX :
                (i == 2) ? 32'sd0 : (i == 3) ? -32'sd1 : $urandom;
            issue(CMD_INSERT, (i % 3 == 0) ? 1 : (i % 3 == 1) ? i + 1 : i / 2 + 1,
                  v, $urandom);
        end

        // full list rejects inserts
        issue(CMD_INSERT, 1, 32'sd9, 32'sd0);
        issue(CMD_INSERT, LIST_CAP + 1, 32'sd9, 32'sd0);

        issue(CMD_LOCATE, 0, VAL_MAX, 32'sd0);
        issue(CMD_LOCATE, 0, 32'sh0001_2345, 32'sd0);

        // tail delete, then the same position is out of range
        issue(CMD_DELETE, LIST_CAP, 32'sd0, 32'sd0);
        issue(CMD_DELETE, LIST_CAP, 32'sd0, 32'sd0);

        issue(CMD_DELETE_MIN, 0, 32'sd0, 32'sd0);
        issue(CMD_REMOVE_VALUE, 0, -32'sd1, 32'sd0);
        issue(CMD_REMOVE_VALUE, 0, 32'sh0001_2345, 32'sd0);

        // bad bounds, then a range spanning everything
        issue(CMD_REMOVE_RANGE, 0, 32'sd5, 32'sd5);
        issue(CMD_REMOVE_RANGE, 0, 32'sd10, -32'sd10);
        issue(CMD_REMOVE_RANGE, 31, VAL_MIN, VAL_MAX);

        issue(CMD_SPARE_A, 31, 32'sd1, 32'sd2);
        issue(CMD_SPARE_B, 0, 32'sd1, 32'sd2);

        // random part, with stretches of back-to-back items
        for (int i = 0; i < RANDOM_CMDS; i++)
            drive_cmd(random_cmd(), (i % 300 < 60) ? 0 : pick_gap());

        cmd_valid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.outstanding() > 0)
        begin
            sb.errors++;
            $display("%0t: %0d result items never arrived", $time, sb.outstanding());
        end

        $display("run covered %0d command items and %0d result items, peak length %0d",
                 sb.accepted, sb.checked, sb.peak);
        $display("inserts refused on a full list: %0d, mismatches: %0d",
                 sb.full_rejects, sb.errors);
        if (sb.errors == 0)
            $display("tb_sequential_list_engine_core passed");
        else
            $display("tb_sequential_list_engine_core failed");
        $finish;
    end

endmodule

`default_nettype wire
